// ===== sv/lbp_pkg.sv =====
`default_nettype none

package lbp_pkg;

    localparam int ACC_BITS       = 32;
    localparam int MAX_FIELD_BITS = 31;
    localparam int CFG_BITS       = 17;
    localparam int USED_BITS      = 20;

    localparam logic [CFG_BITS-1:0] BUFFER_BYTES_RESET = 17'h10000;

    typedef enum logic [1:0] {
        KIND_PUT   = 2'd0,
        KIND_FLUSH = 2'd1,
        KIND_SKIP  = 2'd2,
        KIND_NONE  = 2'd3
    } kind_t;

    typedef enum logic [1:0] {
        STATUS_OK        = 2'd0,
        STATUS_OVERFLOW  = 2'd1,
        STATUS_UNALIGNED = 2'd2
    } status_t;

endpackage

`default_nettype wire

// ===== sv/lsb_first_bit_packer_unit.sv =====
`default_nettype none

// channel   direction  handshake               payload
// in        input      in_valid / in_stall     kind, bit_count, field_value, skip_bytes
// out       output     out_valid / out_stall   word_valid, word_data, word_bytes,
//                                              word_offset, bits_used, status
// cfg       input      cfg_valid / cfg_ready   cfg_data (buffer_bytes)
//
// one item per cycle while in_stall is low; each transaction gives exactly one result
// path: input register, then the shift-or and offset update into the result register
// the accumulator, free bit count and offset advance as an item moves into the result register
// reset clears the state, sets buffer_bytes to 65536; cfg_ready is always high
// out_stall holds the result and backs up into in_stall only when both stages are full
module lsb_first_bit_packer_unit #(
    parameter int OFFSET_BITS = 16
) (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         in_valid,
    output logic                              in_stall,
    input  wire logic [1:0]                   kind,
    input  wire logic [4:0]                   bit_count,
    input  wire logic [30:0]                  field_value,
    input  wire logic [15:0]                  skip_bytes,
    output logic                              out_valid,
    input  wire logic                         out_stall,
    output logic                              word_valid,
    output logic [31:0]                       word_data,
    output logic [2:0]                        word_bytes,
    output logic [OFFSET_BITS-1:0]            word_offset,
    output logic [lbp_pkg::USED_BITS-1:0]     bits_used,
    output logic [1:0]                        status,
    input  wire logic                         cfg_valid,
    output logic                              cfg_ready,
    input  wire logic [lbp_pkg::CFG_BITS-1:0] cfg_data
);
    import lbp_pkg::*;

    localparam int OW = OFFSET_BITS + 1;
    localparam int CW = ((OW > CFG_BITS) ? OW : CFG_BITS) + 1;
    localparam logic [CW-1:0] OFFSET_CAP = {{(CW-1){1'b0}}, 1'b1} << OFFSET_BITS;

    // input stage
    logic        s1_valid_reg;
    logic [1:0]  kind_reg;
    logic [4:0]  bit_count_reg;
    logic [30:0] field_value_reg;
    logic [15:0] skip_bytes_reg;

    // packer state
    logic [ACC_BITS-1:0] acc_reg, acc_next;
    logic [5:0]          free_bits_reg, free_bits_next;
    logic [OW-1:0]       offset_reg, offset_next;
    logic [CFG_BITS-1:0] buffer_bytes_reg;

    // result stage
    logic                 out_valid_reg;
    logic                 word_valid_reg, word_valid_next;
    logic [31:0]          word_data_reg, word_data_next;
    logic [2:0]           word_bytes_reg, word_bytes_next;
    logic [OFFSET_BITS-1:0] word_offset_reg, word_offset_next;
    logic [USED_BITS-1:0] bits_used_reg, bits_used_next;
    status_t              status_reg, status_next;

    logic in_take;
    logic s1_advance;

    assign s1_advance = s1_valid_reg && (!out_valid_reg || !out_stall);
    assign in_stall   = s1_valid_reg && out_valid_reg && out_stall;
    assign in_take    = in_valid && !in_stall;
    assign cfg_ready  = 1'b1;

    always_comb
    begin
        logic [4:0]    n;
        logic [30:0]   v;
        logic [31:0]   mask;
        logic [4:0]    shamt;
        logic [31:0]   acc_or;
        logic          fill;
        logic [5:0]    pending;
        logic [2:0]    flush_bytes;
        logic [31:0]   flush_data;
        logic          emit_en;
        logic [2:0]    emit_bytes;
        logic [31:0]   emit_data;
        logic [CW-1:0] limit;
        logic [CW-1:0] cfg_ext;
        logic [CW-1:0] add;
        logic [CW-1:0] sum;
        logic          do_adv;
        logic          over;
        logic [6:0]    fb_sum;

        acc_next         = acc_reg;
        free_bits_next   = free_bits_reg;
        offset_next      = offset_reg;
        word_valid_next  = 1'b0;
        word_data_next   = '0;
        word_bytes_next  = '0;
        status_next      = STATUS_OK;

        n = (bit_count_reg > 5'(MAX_FIELD_BITS)) ? 5'(MAX_FIELD_BITS) : bit_count_reg;
        mask    = (32'd1 << n) - 32'd1;
        v       = field_value_reg & mask[30:0];
        shamt   = 5'(6'd32 - free_bits_reg);
        acc_or  = acc_reg | ({1'b0, v} << shamt);
        fill    = ({1'b0, n} >= free_bits_reg);

        pending     = 6'd32 - free_bits_reg;
        flush_bytes = 3'((7'(pending) + 7'd7) >> 3);
        for (int i = 0; i < 4; i++)
        begin
            flush_data[8*i +: 8] = (3'(i) < flush_bytes) ? acc_reg[8*i +: 8] : 8'd0;
        end

        emit_en    = 1'b0;
        emit_bytes = '0;
        emit_data  = '0;
        do_adv     = 1'b0;
        add        = '0;
        fb_sum     = '0;

        case (kind_reg)
            KIND_PUT:
            begin
                if (fill)
                begin
                    emit_en    = 1'b1;
                    emit_bytes = 3'd4;
                    emit_data  = acc_or;
                    acc_next   = (free_bits_reg == 6'd32) ? 32'd0 : ({1'b0, v} >> free_bits_reg);
                end
                else
                begin
                    acc_next = acc_or;
                end
                fb_sum         = 7'(free_bits_reg) + (fill ? 7'd32 : 7'd0) - 7'(n);
                free_bits_next = fb_sum[5:0];
            end
            KIND_FLUSH:
            begin
                if (flush_bytes != 3'd0)
                begin
                    emit_en    = 1'b1;
                    emit_bytes = flush_bytes;
                    emit_data  = flush_data;
                end
                acc_next       = '0;
                free_bits_next = 6'd32;
            end
            KIND_SKIP:
            begin
                if (free_bits_reg != 6'd32)
                begin
                    status_next = STATUS_UNALIGNED;
                end
                else
                begin
                    do_adv = 1'b1;
                    add    = CW'(skip_bytes_reg);
                end
            end
            default:
            begin
                acc_next = acc_reg;
            end
        endcase

        // overflow check against the smaller of the buffer size and the offset range
        cfg_ext = CW'(buffer_bytes_reg);
        limit   = (cfg_ext < OFFSET_CAP) ? cfg_ext : OFFSET_CAP;
        over    = (CW'(offset_reg) + CW'(emit_bytes)) > limit;
        if (emit_en)
        begin
            do_adv = 1'b1;
            add    = CW'(emit_bytes);
            if (over)
            begin
                status_next = STATUS_OVERFLOW;
            end
            else
            begin
                word_valid_next = 1'b1;
                word_data_next  = emit_data;
                word_bytes_next = emit_bytes;
            end
        end

        // offset saturates at the top of its range
        sum = CW'(offset_reg) + add;
        if (do_adv)
        begin
            offset_next = (sum > OFFSET_CAP) ? OW'(OFFSET_CAP) : OW'(sum);
        end

        word_offset_next = (emit_en || !do_adv) ? offset_reg[OFFSET_BITS-1:0]
                                                : offset_next[OFFSET_BITS-1:0];
        bits_used_next = USED_BITS'({offset_next, 3'b000})
                       + USED_BITS'(6'd32 - free_bits_next);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg     <= 1'b0;
            out_valid_reg    <= 1'b0;
            acc_reg          <= '0;
            free_bits_reg    <= 6'd32;
            offset_reg       <= '0;
            buffer_bytes_reg <= BUFFER_BYTES_RESET;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                buffer_bytes_reg <= cfg_data;
            end
            if (in_take)
            begin
                s1_valid_reg <= 1'b1;
            end
            else if (s1_advance)
            begin
                s1_valid_reg <= 1'b0;
            end
            if (s1_advance)
            begin
                out_valid_reg <= 1'b1;
                acc_reg       <= acc_next;
                free_bits_reg <= free_bits_next;
                offset_reg    <= offset_next;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            kind_reg        <= kind;
            bit_count_reg   <= bit_count;
            field_value_reg <= field_value;
            skip_bytes_reg  <= skip_bytes;
        end
        if (s1_advance)
        begin
            word_valid_reg  <= word_valid_next;
            word_data_reg   <= word_data_next;
            word_bytes_reg  <= word_bytes_next;
            word_offset_reg <= word_offset_next;
            bits_used_reg   <= bits_used_next;
            status_reg      <= status_next;
        end
    end

    assign out_valid   = out_valid_reg;
    assign word_valid  = word_valid_reg;
    assign word_data   = word_data_reg;
    assign word_bytes  = word_bytes_reg;
    assign word_offset = word_offset_reg;
    assign bits_used   = bits_used_reg;
    assign status      = status_reg;

    a_free_bits_range: assert property (@(posedge clk) disable iff (!rst_n)
        free_bits_reg != 6'd0 && free_bits_reg <= 6'd32)
        else $error("free bit count out of range");

    a_offset_capped: assert property (@(posedge clk) disable iff (!rst_n)
        CW'(offset_reg) <= OFFSET_CAP)
        else $error("write offset beyond its cap");

    a_word_has_bytes: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && word_valid_reg |-> word_bytes_reg != 3'd0 && word_bytes_reg <= 3'd4)
        else $error("emitted word without a byte count");

    a_overflow_drops: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && status_reg == STATUS_OVERFLOW |-> !word_valid_reg)
        else $error("overflowed word still marked valid");

    a_stall_needs_item: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> s1_valid_reg && out_valid_reg)
        else $error("input stalled with a free stage");

    a_state_held: assert property (@(posedge clk) disable iff (!rst_n)
        !s1_advance |=> $stable(offset_reg) && $stable(free_bits_reg))
        else $error("state moved without an item");

endmodule

`default_nettype wire
